### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; clocked on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define TRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define TRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/trd_pkg.sv
package trd_pkg;

  localparam int MAX_TOUCHES_DEF = 5;
  localparam int COORD_BITS_DEF  = 11;

  localparam int POINT_W    = 11;
  localparam int ID_W       = 4;
  localparam int PRESS_W    = 8;
  localparam int EDGE_W     = 2;
  localparam int STATUS_W   = 8;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCHANGE = 3'd4;

  localparam logic [POINT_W-1:0] LIMIT_RESET = 11'h7FF;

  // input item kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // result kinds
  localparam logic RK_POINT     = 1'b0;
  localparam logic RK_FRAME_END = 1'b1;

  // record events that produce a point
  localparam logic [1:0] EV_DOWN    = 2'd0;
  localparam logic [1:0] EV_CONTACT = 2'd2;

  // frame-end touch edges
  localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_PRESS   = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_INVALID = 8'hFF;
  localparam logic [PRESS_W-1:0]  BASE_PRESSURE  = 8'd127;
  localparam logic [PRESS_W-1:0]  PRESSURE_MIN   = 8'd123;
  localparam logic [PRESS_W-1:0]  PRESSURE_MAX   = 8'd131;
  localparam logic signed [3:0]   OFFSET_MAX     = 4'sd4;
  localparam logic signed [3:0]   OFFSET_WRAP    = -4'sd4;

  typedef struct packed {
    logic               kind;
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [ID_W-1:0]    id;
    logic [PRESS_W-1:0] pressure;
    logic               first;
    logic [EDGE_W-1:0]  edge_code;
    logic               last;
  } trd_result_t;

  typedef struct packed {
    logic [POINT_W-1:0] limit_x;
    logic [POINT_W-1:0] limit_y;
    logic               mirror_x;
    logic               mirror_y;
    logic               exchange;
  } trd_cfg_t;

  // up to two results per item; slot_a goes first
  typedef struct packed {
    logic [1:0]  count;
    trd_result_t slot_a;
    trd_result_t slot_b;
  } trd_push_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room;
  } trd_fifo_stat_t;

endpackage

### hw/rtl/trd_frame_core.sv
module trd_frame_core
  import trd_pkg::*;
#(
  parameter int MAX_TOUCHES = MAX_TOUCHES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_kind_i,
  input  logic [STATUS_W-1:0] in_status_byte_i,
  input  logic [WORD_W-1:0]   in_x_word_i,
  input  logic [WORD_W-1:0]   in_y_word_i,
  input  trd_cfg_t            cfg_i,
  input  trd_fifo_stat_t      fifo_stat_i,
  output trd_push_t           push_o
);

  localparam int REM_W  = $clog2(MAX_TOUCHES + 1);
  localparam int CALC_W = (COORD_BITS > POINT_W) ? COORD_BITS : POINT_W;

  logic                in_vld_q, in_vld_d;
  logic                kind_q;
  logic [STATUS_W-1:0] status_q;
  logic [WORD_W-1:0]   xw_q, yw_q;

  logic              frame_open_q, frame_open_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              cur_q, cur_d;     // open frame has a valid point
  logic              prev_q, prev_d;   // last finished frame had a valid point
  logic signed [3:0] off_q, off_d;

  logic              process;
  logic              accept;
  logic [1:0]        ev;
  logic [CALC_W-1:0] x_raw, y_raw, lim_x, lim_y, x_m, y_m;
  logic [3:0]        nib;
  logic [REM_W-1:0]  cnt_sat;
  logic signed [3:0] off_use;
  logic [PRESS_W-1:0] press;
  logic              is_point, do_finish, cur_after, end_emit;
  logic [EDGE_W-1:0] edge_code;
  trd_result_t       point_res, end_res;

  assign process    = in_vld_q && fifo_stat_i.room;
  assign in_stall_o = in_vld_q && !fifo_stat_i.room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (process ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      frame_open_q <= 1'b0;
      rem_q        <= '0;
      cur_q        <= 1'b0;
      prev_q       <= 1'b0;
      off_q        <= '0;
    end else begin
      in_vld_q     <= in_vld_d;
      frame_open_q <= frame_open_d;
      rem_q        <= rem_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      off_q        <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_kind_i;
      status_q <= in_status_byte_i;
      xw_q     <= in_x_word_i;
      yw_q     <= in_y_word_i;
    end
  end

  // record decode, mirroring (saturating at zero) and axis exchange
  assign ev    = xw_q[15:14];
  assign x_raw = CALC_W'(xw_q[COORD_BITS-1:0]);
  assign y_raw = CALC_W'(yw_q[COORD_BITS-1:0]);
  assign lim_x = CALC_W'(cfg_i.limit_x);
  assign lim_y = CALC_W'(cfg_i.limit_y);
  assign x_m   = !cfg_i.mirror_x ? x_raw : ((x_raw > lim_x) ? '0 : lim_x - x_raw);
  assign y_m   = !cfg_i.mirror_y ? y_raw : ((y_raw > lim_y) ? '0 : lim_y - y_raw);

  assign nib     = status_q[3:0];
  assign cnt_sat = (nib > 4'(MAX_TOUCHES)) ? REM_W'(MAX_TOUCHES) : REM_W'(nib);

  assign off_use = (off_q > OFFSET_MAX) ? OFFSET_WRAP : off_q;
  assign press   = BASE_PRESSURE + {{(PRESS_W-4){off_use[3]}}, off_use};

  always_comb begin
    frame_open_d = frame_open_q;
    rem_d        = rem_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    off_d        = off_q;
    is_point     = 1'b0;
    do_finish    = 1'b0;
    cur_after    = cur_q;
    if (process) begin
      if (kind_q == KIND_STATUS) begin
        frame_open_d = 1'b0;
        rem_d        = '0;
        cur_d        = 1'b0;
        cur_after    = 1'b0;
        if (status_q != STATUS_INVALID) begin
          if (cnt_sat == '0) begin
            do_finish = 1'b1;
          end else begin
            frame_open_d = 1'b1;
            rem_d        = cnt_sat;
          end
        end
      end else if (frame_open_q) begin
        if (ev == EV_DOWN || ev == EV_CONTACT) begin
          is_point  = 1'b1;
          off_d     = off_use + 4'sd1;
          cur_after = 1'b1;
          cur_d     = 1'b1;
        end
        // an open frame always has at least one record left
        rem_d = rem_q - REM_W'(1);
        if (rem_d == '0) begin
          do_finish = 1'b1;
        end
      end
    end
    if (do_finish) begin
      frame_open_d = 1'b0;
      rem_d        = '0;
      prev_d       = cur_after;
      cur_d        = 1'b0;
    end
  end

  assign end_emit = do_finish && (cur_after || prev_q);

  always_comb begin
    edge_code = EDGE_NONE;
    if (cur_after && !prev_q) begin
      edge_code = EDGE_PRESS;
    end else if (!cur_after && prev_q) begin
      edge_code = EDGE_RELEASE;
    end
  end

  always_comb begin
    point_res.kind      = RK_POINT;
    point_res.x         = cfg_i.exchange ? y_m[POINT_W-1:0] : x_m[POINT_W-1:0];
    point_res.y         = cfg_i.exchange ? x_m[POINT_W-1:0] : y_m[POINT_W-1:0];
    point_res.id        = yw_q[15:12];
    point_res.pressure  = press;
    point_res.first     = !cur_q;
    point_res.edge_code = EDGE_NONE;
    point_res.last      = !end_emit;

    end_res.kind      = RK_FRAME_END;
    end_res.x         = '0;
    end_res.y         = '0;
    end_res.id        = '0;
    end_res.pressure  = '0;
    end_res.first     = 1'b0;
    end_res.edge_code = edge_code;
    end_res.last      = 1'b1;
  end

  assign push_o.slot_a = is_point ? point_res : end_res;
  assign push_o.slot_b = end_res;
  assign push_o.count  = {1'b0, is_point} + {1'b0, end_emit};

endmodule

### hw/rtl/trd_result_fifo.sv
module trd_result_fifo
  import trd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  trd_push_t      push_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output trd_result_t    out_data_o,
  output trd_fifo_stat_t stat_o
);

  trd_result_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign wr_ptr_nxt = FIFO_PTR_W'(wr_ptr_q + 1'b1);
  assign wr_ptr_d   = FIFO_PTR_W'(wr_ptr_q + push_i.count);
  assign rd_ptr_d   = pop ? FIFO_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
  assign count_d    = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop);

  // room for a full two-result item
  assign stat_o.count = count_q;
  assign stat_o.room  = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.slot_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.slot_b;
    end
  end

endmodule

### hw/rtl/touch_report_decoder.sv
// Multi-touch frame decoder. A status item opens a frame of up to MAX_TOUCHES
// record items; down and contact records give a point result, and the end of
// a frame gives a frame-end result with the press/release edge if this or the
// last frame held a point. An item waits in the input register while a short
// decode writes its zero to two results into a four-entry result queue; one
// item is taken every cycle, but the input stalls while the queue has fewer
// than two free entries. Results leave one per cycle unless out_stall_i is
// high. Configuration writes are taken every cycle (ready is always high).
`include "assert_macros.svh"

module touch_report_decoder
  import trd_pkg::*;
#(
  parameter int MAX_TOUCHES = MAX_TOUCHES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_kind_i,
  input  logic [STATUS_W-1:0]   in_status_byte_i,
  input  logic [WORD_W-1:0]     in_x_word_i,
  input  logic [WORD_W-1:0]     in_y_word_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_result_kind_o,
  output logic [POINT_W-1:0]    out_point_x_o,
  output logic [POINT_W-1:0]    out_point_y_o,
  output logic [ID_W-1:0]       out_track_id_o,
  output logic [PRESS_W-1:0]    out_pressure_o,
  output logic                  out_first_point_o,
  output logic [EDGE_W-1:0]     out_touch_edge_o,
  output logic                  out_last_o
);

  trd_cfg_t       cfg_q, cfg_d;
  trd_push_t      push;
  trd_fifo_stat_t fifo_stat;
  trd_result_t    res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LIMIT_X:  cfg_d.limit_x  = cfg_data_i[POINT_W-1:0];
        CFG_LIMIT_Y:  cfg_d.limit_y  = cfg_data_i[POINT_W-1:0];
        CFG_MIRROR_X: cfg_d.mirror_x = cfg_data_i[0];
        CFG_MIRROR_Y: cfg_d.mirror_y = cfg_data_i[0];
        CFG_EXCHANGE: cfg_d.exchange = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_x  <= LIMIT_RESET;
      cfg_q.limit_y  <= LIMIT_RESET;
      cfg_q.mirror_x <= 1'b0;
      cfg_q.mirror_y <= 1'b0;
      cfg_q.exchange <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  trd_frame_core #(
    .MAX_TOUCHES(MAX_TOUCHES),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_status_byte_i(in_status_byte_i),
    .in_x_word_i     (in_x_word_i),
    .in_y_word_i     (in_y_word_i),
    .cfg_i           (cfg_q),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push)
  );

  trd_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (res),
    .stat_o     (fifo_stat)
  );

  assign out_result_kind_o = res.kind;
  assign out_point_x_o     = res.x;
  assign out_point_y_o     = res.y;
  assign out_track_id_o    = res.id;
  assign out_pressure_o    = res.pressure;
  assign out_first_point_o = res.first;
  assign out_touch_edge_o  = res.edge_code;
  assign out_last_o        = res.last;

  `TRD_ASSERT(a_fifo_bound, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `TRD_ASSERT_IMPL(a_end_last, out_valid_o && out_result_kind_o, out_last_o, "frame end not last")
  `TRD_ASSERT_IMPL(a_point_press, out_valid_o && !out_result_kind_o,
    out_pressure_o >= PRESSURE_MIN && out_pressure_o <= PRESSURE_MAX &&
    out_touch_edge_o == EDGE_NONE, "bad point result")

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import trd_pkg::*;

  localparam logic [1:0] EV_UP    = 2'd1;
  localparam logic [1:0] EV_NONE  = 2'd3;
  localparam int         IDLE_PCT = 9;
  localparam int         SETTLE   = 8;
  localparam int         PHASE_ITEMS = 290;

  typedef struct packed {
    logic               barrier;  // sender waits here until all results are in
    logic               kind;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]  x_word;
    logic [WORD_W-1:0]  y_word;
  } stim_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  in_kind_i = KIND_STATUS;
  logic [STATUS_W-1:0]   in_status_byte_i = '0;
  logic [WORD_W-1:0]     in_x_word_i = '0;
  logic [WORD_W-1:0]     in_y_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  out_result_kind_o;
  logic [POINT_W-1:0]    out_point_x_o;
  logic [POINT_W-1:0]    out_point_y_o;
  logic [ID_W-1:0]       out_track_id_o;
  logic [PRESS_W-1:0]    out_pressure_o;
  logic                  out_first_point_o;
  logic [EDGE_W-1:0]     out_touch_edge_o;
  logic                  out_last_o;

  touch_report_decoder uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_kind_i, .in_status_byte_i, .in_x_word_i, .in_y_word_i,
    .out_valid_o, .out_stall_i, .out_result_kind_o, .out_point_x_o, .out_point_y_o,
    .out_track_id_o, .out_pressure_o, .out_first_point_o, .out_touch_edge_o, .out_last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder state and register copy
  logic [POINT_W-1:0] lim_x = LIMIT_RESET, lim_y = LIMIT_RESET;
  logic               mir_x = 1'b0, mir_y = 1'b0, swap_xy = 1'b1;
  logic [2:0]         prev_points = '0, cur_points = '0, recs_left = '0;
  logic               frame_open = 1'b0;
  int                 press_offset = 0;

  stim_t       pending_items[$];
  trd_result_t expected_results[$];
  stim_t       driven = '0;
  logic        calm = 1'b0;

  int unsigned errors = 0, items_sent = 0, points_seen = 0, frame_ends_seen = 0;
  int unsigned settings_used = 1;

  // closes the frame; returns 1 when a frame-end result is due
  function automatic logic close_frame(output logic [EDGE_W-1:0] edge_v);
    logic cur, prev;
    cur = cur_points != 0;
    prev = prev_points != 0;
    frame_open = 1'b0;
    recs_left = '0;
    edge_v = EDGE_NONE;
    if (cur && !prev) edge_v = EDGE_PRESS;
    else if (!cur && prev) edge_v = EDGE_RELEASE;
    prev_points = cur_points;
    cur_points = '0;
    return cur || prev;
  endfunction

  function automatic void decode_item(stim_t it);
    trd_result_t res [2];
    int n;
    logic [1:0] ev;
    logic [POINT_W-1:0] px, py, t;
    logic [EDGE_W-1:0] edge_v;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (it.kind == KIND_STATUS) begin
      frame_open = 1'b0;
      recs_left = '0;
      cur_points = '0;
      if (it.status != STATUS_INVALID) begin
        if (it.status[3:0] == 4'd0) begin
          if (close_frame(edge_v)) begin
            res[0].kind = RK_FRAME_END;
            res[0].edge_code = edge_v;
            n = 1;
          end
        end else begin
          frame_open = 1'b1;
          recs_left = (it.status[3:0] > 4'(MAX_TOUCHES_DEF)) ? 3'(MAX_TOUCHES_DEF)
                                                              : it.status[2:0];
        end
      end
    end else if (frame_open) begin
      ev = it.x_word[15:14];
      px = it.x_word[POINT_W-1:0];
      py = it.y_word[POINT_W-1:0];
      if (ev == EV_DOWN || ev == EV_CONTACT) begin
        if (press_offset > 4) press_offset = -4;
        if (mir_x) px = (px > lim_x) ? '0 : lim_x - px;
        if (mir_y) py = (py > lim_y) ? '0 : lim_y - py;
        if (swap_xy) begin
          t = px;
          px = py;
          py = t;
        end
        res[0].kind = RK_POINT;
        res[0].x = px;
        res[0].y = py;
        res[0].id = it.y_word[15:12];
        res[0].pressure = 8'(int'(BASE_PRESSURE) + press_offset);
        res[0].first = cur_points == 0;
        n = 1;
        press_offset++;
        cur_points++;
      end
      if (recs_left > 0) recs_left--;
      if (recs_left == 0 && close_frame(edge_v)) begin
        res[n].kind = RK_FRAME_END;
        res[n].edge_code = edge_v;
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endfunction

  // sender
  always @(posedge clk_i) begin
    stim_t nxt;
    logic go;
    go = 1'b0;
    nxt = '0;
    if (in_valid_i && !in_stall_o) begin
      decode_item(driven);
      items_sent++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (pending_items.size() > 0 && pending_items[0].barrier &&
          expected_results.size() == 0)
        void'(pending_items.pop_front());
      if (pending_items.size() > 0 && !pending_items[0].barrier &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        go = 1'b1;
      end
      in_valid_i <= go;
      if (go) begin
        driven <= nxt;
        in_kind_i <= nxt.kind;
        in_status_byte_i <= nxt.status;
        in_x_word_i <= nxt.x_word;
        in_y_word_i <= nxt.y_word;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    trd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d x %0d y %0d edge %0d",
                 $time, out_result_kind_o, out_point_x_o, out_point_y_o, out_touch_edge_o);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_result_kind_o);
        check_field("point_x", want.x, out_point_x_o);
        check_field("point_y", want.y, out_point_y_o);
        check_field("track_id", want.id, out_track_id_o);
        check_field("pressure", want.pressure, out_pressure_o);
        check_field("first_point", want.first, out_first_point_o);
        check_field("touch_edge", want.edge_code, out_touch_edge_o);
        check_field("last", want.last, out_last_o);
        if (want.kind == RK_POINT) points_seen++;
        else frame_ends_seen++;
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic stim_t status_item(logic [STATUS_W-1:0] s);
    stim_t it;
    it = '0;
    it.kind = KIND_STATUS;
    it.status = s;
    it.x_word = 16'($urandom);
    it.y_word = 16'($urandom);
    return it;
  endfunction

  // unused word bits get random junk
  function automatic stim_t record_item(logic [1:0] ev, logic [10:0] x, logic [3:0] id,
                                        logic [10:0] y);
    stim_t it;
    it = '0;
    it.kind = KIND_RECORD;
    it.status = 8'($urandom);
    it.x_word = {ev, 3'($urandom), x};
    it.y_word = {id, 1'($urandom), y};
    return it;
  endfunction

  function automatic logic [10:0] pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return 11'h7FF;
      2: return 11'($urandom_range(15));
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_event(logic idle_only);
    int r;
    r = $urandom_range(99);
    if (idle_only) return r < 50 ? EV_UP : EV_NONE;
    if (r < 40) return EV_DOWN;
    if (r < 80) return EV_CONTACT;
    if (r < 90) return EV_UP;
    return EV_NONE;
  endfunction

  // queues one frame or a bit of noise; returns the items that count
  function automatic int queue_random();
    int r, nrec, nib;
    logic idle_only;
    r = $urandom_range(99);
    if (r < 5) begin
      pending_items.push_back(record_item(2'($urandom), pick_coord(), 4'($urandom),
                                          pick_coord()));
      return 0;
    end
    if (r < 9) begin
      pending_items.push_back(status_item(STATUS_INVALID));
      return 0;
    end
    nib = $urandom_range(15);
    if ($urandom_range(99) < 30) nib = $urandom_range(1, MAX_TOUCHES_DEF);
    pending_items.push_back(status_item({4'($urandom), 4'(nib)}));
    nrec = (nib > MAX_TOUCHES_DEF) ? MAX_TOUCHES_DEF : nib;
    if (nrec > 0 && $urandom_range(99) < 8) nrec = $urandom_range(nrec - 1);
    idle_only = $urandom_range(99) < 15;
    for (int i = 0; i < nrec; i++)
      pending_items.push_back(record_item(pick_event(idle_only), pick_coord(),
                                          4'($urandom), pick_coord()));
    return 1 + nrec;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LIMIT_X:  lim_x = data;
      CFG_LIMIT_Y:  lim_y = data;
      CFG_MIRROR_X: mir_x = data[0];
      CFG_MIRROR_Y: mir_y = data[0];
      CFG_EXCHANGE: swap_xy = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [10:0] lx, logic [10:0] ly, logic mx, logic my, logic ex);
    write_reg(CFG_LIMIT_X, lx);
    write_reg(CFG_LIMIT_Y, ly);
    write_reg(CFG_MIRROR_X, CFG_DATA_W'(mx));
    write_reg(CFG_MIRROR_Y, CFG_DATA_W'(my));
    write_reg(CFG_EXCHANGE, CFG_DATA_W'(ex));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int target);
    int done_items;
    logic paused;
    done_items = 0;
    paused = 1'b0;
    while (done_items < target) begin
      done_items += queue_random();
      if (!paused && done_items >= target / 2) begin
        pending_items.push_back('{barrier: 1'b1, default: '0});
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed frames under reset settings
    pending_items.push_back(status_item(8'h00));
    pending_items.push_back(record_item(EV_DOWN, 11'd5, 4'd1, 11'd6));      // no frame open
    pending_items.push_back(status_item(8'h01));
    pending_items.push_back(record_item(EV_DOWN, 11'd0, 4'd0, 11'h7FF));
    pending_items.push_back(status_item(8'h0F));                             // count saturates
    pending_items.push_back(record_item(EV_DOWN, 11'h7FF, 4'd15, 11'd0));
    pending_items.push_back(record_item(EV_CONTACT, 11'd1, 4'd5, 11'd1));
    pending_items.push_back(record_item(EV_UP, 11'd100, 4'd2, 11'd200));
    pending_items.push_back(record_item(EV_NONE, 11'h7FF, 4'd3, 11'h7FF));
    pending_items.push_back(record_item(EV_CONTACT, 11'h7FF, 4'd9, 11'h7FF));
    pending_items.push_back(status_item(8'hF2));
    pending_items.push_back(record_item(EV_UP, 11'd3, 4'd4, 11'd4));
    pending_items.push_back(record_item(EV_NONE, 11'd7, 4'd8, 11'd8));
    pending_items.push_back(status_item(8'h00));
    pending_items.push_back(status_item(8'h03));
    pending_items.push_back(record_item(EV_DOWN, 11'd300, 4'd6, 11'd400));
    pending_items.push_back(status_item(STATUS_INVALID));                    // drops the frame
    pending_items.push_back(record_item(EV_CONTACT, 11'd10, 4'd7, 11'd11));
    pending_items.push_back(status_item(8'h04));
    pending_items.push_back(record_item(EV_CONTACT, 11'd20, 4'd10, 11'd21));
    pending_items.push_back(status_item(8'h01));                             // restarts mid-frame
    pending_items.push_back(record_item(EV_DOWN, 11'd30, 4'd12, 11'd31));
    pending_items.push_back(status_item(8'h00));
    pending_items.push_back(status_item(8'h80));
    wait_drained();

    run_random(PHASE_ITEMS);
    set_config(11'h7FF, 11'h7FF, 1'b1, 1'b1, 1'b0);
    run_random(PHASE_ITEMS);
    set_config(11'd0, 11'd0, 1'b1, 1'b1, 1'b1);
    run_random(PHASE_ITEMS);
    set_config(11'($urandom), 11'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    calm = 1'b0;
    set_config(11'($urandom_range(63)), 11'h7FF, 1'b1, 1'b0, 1'b0);
    run_random(PHASE_ITEMS);
    set_config(11'h7FF, 11'($urandom_range(1000, 1100)), 1'b0, 1'b1, 1'b1);
    run_random(PHASE_ITEMS);

    $display("%0d items sent, %0d points and %0d frame ends checked",
             items_sent, points_seen, frame_ends_seen);
    $display("%0d register settings: mirroring, axis swap, zero and full limits",
             settings_used);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### touch_report_decoder.f
+incdir+hw/rtl
hw/rtl/trd_pkg.sv
hw/rtl/trd_frame_core.sv
hw/rtl/trd_result_fifo.sv
hw/rtl/touch_report_decoder.sv
test/tb.sv
